### hdl/dct8_pkg.sv
// ----------------------------------------------------------------------------
// dct8_pkg: shared types and constants of the 8x8 forward integer DCT
// Holds widths, the transform constants and the word types of the channels.
// ----------------------------------------------------------------------------
package dct8_pkg;
	localparam int unsigned SampleWidth = 16;
	localparam int unsigned BlockSize = 64;
	localparam int unsigned IdxWidth = 6;
	localparam int unsigned QueueDepth = 2;

	localparam int unsigned RowRotShift = 10;
	localparam int unsigned ColEvenShift = 3;
	localparam int unsigned ColRotShift = 13;

	localparam logic signed [11:0] C1420 = 12'sd1420;
	localparam logic signed [11:0] C1338 = 12'sd1338;
	localparam logic signed [11:0] C1204 = 12'sd1204;
	localparam logic signed [11:0] C805 = 12'sd805;
	localparam logic signed [11:0] C554 = 12'sd554;
	localparam logic signed [11:0] C283 = 12'sd283;

	typedef logic signed [SampleWidth-1:0] sample_t;

	typedef struct packed {
		sample_t coefficient;
		logic    last;
	} coef_word_t;
endpackage

### hdl/dct8_stream_if.sv
// ----------------------------------------------------------------------------
// dct8_stream_if: valid/ready channel
// Carries one payload word per handshake between a source and a sink.
// ----------------------------------------------------------------------------
interface dct8_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

### hdl/dct8_front.sv
// ----------------------------------------------------------------------------
// dct8_front: sample collector
// Counts incoming samples and hands each one, with its position, to the queue.
// ----------------------------------------------------------------------------
module dct8_front (
	input  logic                                clk,
	input  logic                                arst_n,
	dct8_stream_if.sink                         in_ch,
	output logic                                push,
	output logic [dct8_pkg::IdxWidth-1:0]       push_idx,
	output dct8_pkg::sample_t                   push_sample,
	input  logic                                q_full
);
	logic [dct8_pkg::IdxWidth-1:0] count_q;

	assign in_ch.ready = !q_full;
	assign push = in_ch.valid && !q_full;
	assign push_idx = count_q;
	assign push_sample = in_ch.payload;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (push) begin
			count_q <= count_q + 1'b1;
		end
	end
endmodule

### hdl/dct8_queue.sv
// ----------------------------------------------------------------------------
// dct8_queue: short queue between collector and transform engine
// A small FIFO of indexed sample words so each side can stall on its own.
// ----------------------------------------------------------------------------
module dct8_queue (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	input  logic [dct8_pkg::IdxWidth-1:0] push_idx,
	input  dct8_pkg::sample_t             push_sample,
	output logic                          full,
	output logic                          not_empty,
	output logic [dct8_pkg::IdxWidth-1:0] head_idx,
	output dct8_pkg::sample_t             head_sample,
	input  logic                          pop
);
	localparam int unsigned Depth = dct8_pkg::QueueDepth;

	logic [dct8_pkg::IdxWidth-1:0] idx_q [Depth];
	dct8_pkg::sample_t             smp_q [Depth];
	logic                          wp_q, rp_q;
	logic [1:0]                    cnt_q;

	assign full = (cnt_q == 2'(Depth));
	assign not_empty = (cnt_q != 2'd0);
	assign head_idx = idx_q[rp_q];
	assign head_sample = smp_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			idx_q[wp_q] <= push_idx;
			smp_q[wp_q] <= push_sample;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end
endmodule

### hdl/dct8_engine.sv
// ----------------------------------------------------------------------------
// dct8_engine: transform engine
// Stores one block, runs eight row and eight column passes through one
// butterfly datapath, then streams the 64 coefficients out.
// ----------------------------------------------------------------------------
module dct8_engine (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          q_not_empty,
	input  logic [dct8_pkg::IdxWidth-1:0] q_idx,
	input  dct8_pkg::sample_t             q_sample,
	output logic                          q_pop,
	dct8_stream_if.source                 out_ch
);
	typedef enum logic [5:0] {
		ST_FILL = 6'b000001,
		ST_LOAD = 6'b000010,
		ST_BFLY = 6'b000100,
		ST_CALC = 6'b001000,
		ST_WBK  = 6'b010000,
		ST_OUT  = 6'b100000
	} state_t;

	dct8_pkg::sample_t             blk_mem [dct8_pkg::BlockSize];
	dct8_pkg::sample_t             rd_q;
	dct8_pkg::sample_t             v_q [8];
	state_t                        state_q;
	logic [3:0]                    pass_q;   // 0..7 rows, 8..15 columns
	logic [3:0]                    step_q;
	logic [dct8_pkg::IdxWidth-1:0] out_idx_q;
	logic signed [16:0]            d_q [4];
	logic signed [18:0]            e_q [2], f_q [2];
	logic signed [31:0]            r_q [8];
	logic                          out_valid_q;

	logic                          is_col;
	logic                          out_take;
	logic [2:0]                    lane;
	logic [2:0]                    pos;
	logic [dct8_pkg::IdxWidth-1:0] pass_addr;
	logic [dct8_pkg::IdxWidth-1:0] rd_addr;
	logic [dct8_pkg::IdxWidth-1:0] wr_addr;
	logic                          wr_en;
	dct8_pkg::sample_t             wr_data;
	dct8_pkg::sample_t             wbk_data;
	logic signed [16:0]            a [4], dv [4];

	function automatic dct8_pkg::sample_t rot(input logic signed [31:0] v, input logic col);
		logic signed [31:0] s;
		s = col ? (v >>> dct8_pkg::ColRotShift) : (v >>> dct8_pkg::RowRotShift);
		return s[15:0];
	endfunction

	function automatic dct8_pkg::sample_t even(input logic signed [31:0] v, input logic col);
		logic signed [31:0] s;
		s = col ? (v >>> dct8_pkg::ColEvenShift) : v;
		return s[15:0];
	endfunction

	assign is_col = pass_q[3];
	assign lane = pass_q[2:0];
	assign pos = step_q[2:0];
	assign pass_addr = is_col ? {pos, lane} : {lane, pos};
	assign out_take = out_valid_q && out_ch.ready;

	// The read address runs one word ahead while the output advances, so in ST_OUT the
	// registered read data always holds the word at out_idx_q.
	always_comb begin
		if (state_q == ST_LOAD) begin
			rd_addr = pass_addr;
		end else if (out_take) begin
			rd_addr = out_idx_q + 1'b1;
		end else begin
			rd_addr = out_idx_q;
		end
	end

	always_comb begin
		if (pos == 3'd0 || pos == 3'd4) begin
			wbk_data = even(r_q[pos], is_col);
		end else begin
			wbk_data = rot(r_q[pos], is_col);
		end
	end

	assign wr_en = ((state_q == ST_FILL) && q_not_empty) || (state_q == ST_WBK);
	assign wr_addr = (state_q == ST_WBK) ? pass_addr : q_idx;
	assign wr_data = (state_q == ST_WBK) ? wbk_data : q_sample;

	always_comb begin
		for (int k = 0; k < 4; k++) begin
			a[k] = 17'(v_q[k]) + 17'(v_q[7-k]);
			dv[k] = 17'(v_q[k]) - 17'(v_q[7-k]);
		end
	end

	assign q_pop = (state_q == ST_FILL) && q_not_empty;
	assign out_ch.valid = out_valid_q;
	assign out_ch.payload.coefficient = rd_q;
	assign out_ch.payload.last = (out_idx_q == 6'(dct8_pkg::BlockSize - 1));

	always_ff @(posedge clk) begin
		if (wr_en) blk_mem[wr_addr] <= wr_data;
		rd_q <= blk_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_LOAD && step_q != 4'd0) v_q[3'(step_q - 4'd1)] <= rd_q;
		if (state_q == ST_BFLY) begin
			for (int k = 0; k < 4; k++) d_q[k] <= dv[k];
			e_q[0] <= 19'(a[0]) + 19'(a[3]);
			e_q[1] <= 19'(a[0]) - 19'(a[3]);
			f_q[0] <= 19'(a[1]) + 19'(a[2]);
			f_q[1] <= 19'(a[1]) - 19'(a[2]);
		end
		if (state_q == ST_CALC) begin
			r_q[0] <= 32'(e_q[0]) + 32'(f_q[0]);
			r_q[4] <= 32'(e_q[0]) - 32'(f_q[0]);
			r_q[2] <= e_q[1] * dct8_pkg::C1338 + f_q[1] * dct8_pkg::C554;
			r_q[6] <= e_q[1] * dct8_pkg::C554 - f_q[1] * dct8_pkg::C1338;
			r_q[7] <= d_q[0] * dct8_pkg::C283 - d_q[1] * dct8_pkg::C805
				+ d_q[2] * dct8_pkg::C1204 - d_q[3] * dct8_pkg::C1420;
			r_q[5] <= d_q[0] * dct8_pkg::C805 - d_q[1] * dct8_pkg::C1420
				+ d_q[2] * dct8_pkg::C283 + d_q[3] * dct8_pkg::C1204;
			r_q[3] <= d_q[0] * dct8_pkg::C1204 - d_q[1] * dct8_pkg::C283
				- d_q[2] * dct8_pkg::C1420 - d_q[3] * dct8_pkg::C805;
			r_q[1] <= d_q[0] * dct8_pkg::C1420 + d_q[1] * dct8_pkg::C1204
				+ d_q[2] * dct8_pkg::C805 + d_q[3] * dct8_pkg::C283;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_FILL;
			pass_q <= '0;
			step_q <= '0;
			out_idx_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_FILL: begin
					if (q_not_empty && q_idx == 6'(dct8_pkg::BlockSize - 1)) begin
						state_q <= ST_LOAD;
						pass_q <= '0;
						step_q <= '0;
					end
				end
				ST_LOAD: begin
					// Read data arrives in the cycle after its address, hence nine steps.
					if (step_q == 4'd8) begin
						state_q <= ST_BFLY;
						step_q <= '0;
					end else begin
						step_q <= step_q + 1'b1;
					end
				end
				ST_BFLY: state_q <= ST_CALC;
				ST_CALC: state_q <= ST_WBK;
				ST_WBK: begin
					if (step_q == 4'd7) begin
						step_q <= '0;
						pass_q <= pass_q + 1'b1;
						if (pass_q == 4'hF) begin
							state_q <= ST_OUT;
							out_idx_q <= '0;
							out_valid_q <= 1'b1;
						end else begin
							state_q <= ST_LOAD;
						end
					end else begin
						step_q <= step_q + 1'b1;
					end
				end
				ST_OUT: begin
					if (out_take) begin
						out_idx_q <= out_idx_q + 1'b1;
						if (out_idx_q == 6'(dct8_pkg::BlockSize - 1)) begin
							out_valid_q <= 1'b0;
							state_q <= ST_FILL;
						end
					end
				end
				default: state_q <= ST_FILL;
			endcase
		end
	end
endmodule

### hdl/dct_8x8_forward_integer.sv
// ----------------------------------------------------------------------------
// dct_8x8_forward_integer: 8x8 forward integer DCT
// Collects 64 samples, transforms the block, streams 64 coefficients.
// ----------------------------------------------------------------------------
//  channel   | direction | word
//  ----------+-----------+---------------------------------
//  in_ch     | sink      | sample (16b signed)
//  out_ch    | source    | coefficient (16b signed), last
//
// Filling takes one sample per cycle while the engine is collecting.
// The engine then runs 16 passes, each of which reads the eight values,
// runs the butterfly, multiplies and writes the eight results back, then
// emits 64 words, one per cycle while out_ch.ready is high. Input stalls
// while the engine transforms or drains; the two-word queue absorbs the
// first samples. Reset clears the count, queue and state.
// ----------------------------------------------------------------------------
module dct_8x8_forward_integer (
	input  logic          clk,
	input  logic          arst_n,
	dct8_stream_if.sink   in_ch,
	dct8_stream_if.source out_ch
);
	logic                          push, q_full, q_not_empty, q_pop;
	logic [dct8_pkg::IdxWidth-1:0] push_idx, q_idx;
	dct8_pkg::sample_t             push_sample, q_sample;

	dct8_front u_front (
		.clk, .arst_n, .in_ch,
		.push, .push_idx, .push_sample, .q_full
	);

	dct8_queue u_queue (
		.clk, .arst_n, .push, .push_idx, .push_sample,
		.full(q_full), .not_empty(q_not_empty),
		.head_idx(q_idx), .head_sample(q_sample), .pop(q_pop)
	);

	dct8_engine u_engine (
		.clk, .arst_n, .q_not_empty, .q_idx, .q_sample, .q_pop, .out_ch
	);
endmodule

### hdl/dct8_checker.sv
// ----------------------------------------------------------------------------
// dct8_port_checks: port-level checks
// Watches the output channel of the transform top level.
// ----------------------------------------------------------------------------
module dct8_port_checks (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic out_last
);
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("output word dropped while stalled");

	a_last_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_last))
		else $error("last flag changed while stalled");

	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && out_last |=> !out_valid)
		else $error("output continues after last word");

	a_reset_quiet: assert property (@(posedge clk) $rose(arst_n) |-> !out_valid)
		else $error("output valid right after reset");
endmodule

bind dct_8x8_forward_integer dct8_port_checks u_checker (
	.clk(clk), .arst_n(arst_n),
	.in_valid(in_ch.valid), .in_ready(in_ch.ready),
	.out_valid(out_ch.valid), .out_ready(out_ch.ready),
	.out_last(out_ch.payload.last)
);
